// ===== src/assert_macros.svh =====
// Assertion helpers, included by the top-level cache file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== src/arp_pkg.sv =====
`default_nettype none

package arp_pkg;

   localparam logic        KIND_INSERT  = 1'b0;
   localparam logic        KIND_LOOKUP  = 1'b1;

   // Register index, taken from address bit 2.
   localparam logic        REG_TTL      = 1'b0;

   localparam logic [31:0] RESET_TTL_MS = 32'd30000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture a new item
      logic wr_en;      // write the captured item into the store
      logic wr_victim;  // write at the round-robin slot and advance it
      logic rsp_load;   // present a lookup result
      logic rsp_hit;    // result is a hit
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic key_match;  // entry just read holds the item's key
      logic live;       // entry just read has not expired
      logic is_lookup;  // captured item is a lookup
   } stat_type;

endpackage

`default_nettype wire

// ===== src/arp_ctrl.sv =====
`default_nettype none

module arp_ctrl #(
   parameter int ENTRIES = 16,
   localparam int IDXW = $clog2(ENTRIES)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire arp_pkg::stat_type status,
   output arp_pkg::cmd_type       cmd,
   output logic [IDXW-1:0]        rd_addr,
   output logic [IDXW-1:0]        wr_addr
);
   import arp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE
   } state_type;

   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

   state_type       state_ff;
   logic [IDXW-1:0] issue_ff;
   logic [IDXW-1:0] cmp_idx_ff;
   logic            cmp_vld_ff;
   logic [IDXW-1:0] wr_addr_ff;
   logic            wr_vic_ff;

   logic found;
   logic last;
   logic done;

   // An insert matches on the key alone; a lookup also needs a live entry.
   assign found = status.key_match && (!status.is_lookup || status.live);
   assign last  = (cmp_idx_ff == LAST_IDX);
   assign done  = cmp_vld_ff && (found || last);

   assign busy    = (state_ff != S_IDLE);
   assign rd_addr = issue_ff;
   assign wr_addr = wr_addr_ff;

   always_comb begin
      cmd.load      = start && (state_ff == S_IDLE);
      cmd.wr_en     = (state_ff == S_WRITE);
      cmd.wr_victim = wr_vic_ff;
      cmd.rsp_load  = (state_ff == S_SCAN) && done && status.is_lookup;
      cmd.rsp_hit   = found;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         issue_ff   <= '0;
         cmp_idx_ff <= '0;
         cmp_vld_ff <= 1'b0;
         wr_addr_ff <= '0;
         wr_vic_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               cmp_vld_ff <= 1'b0;
               if (start) begin
                  state_ff <= S_SCAN;
                  issue_ff <= '0;
               end
            end
            S_SCAN: begin
               // Reads run one entry ahead of the compare.
               cmp_idx_ff <= issue_ff;
               cmp_vld_ff <= !done;
               if (issue_ff != LAST_IDX) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               if (done) begin
                  if (status.is_lookup) begin
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff   <= S_WRITE;
                     wr_addr_ff <= cmp_idx_ff;
                     wr_vic_ff  <= !found;
                  end
               end
            end
            S_WRITE: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/arp_dpath.sv =====
`default_nettype none

module arp_dpath #(
   parameter int ENTRIES = 16,
   localparam int IDXW = $clog2(ENTRIES)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire arp_pkg::cmd_type cmd,
   input  wire logic [IDXW-1:0]  rd_addr,
   input  wire logic [IDXW-1:0]  wr_addr,
   input  wire logic             req_kind,
   input  wire logic [31:0]      req_ip_addr,
   input  wire logic [47:0]      req_mac_in,
   input  wire logic [31:0]      req_now_ms,
   input  wire logic             cfg_we,
   input  wire logic [31:0]      cfg_wdata,
   output logic [31:0]           ttl,
   output arp_pkg::stat_type     status,
   output logic                  rsp_strobe,
   output logic                  rsp_hit,
   output logic [47:0]           rsp_mac_out
);
   import arp_pkg::*;

   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

   logic [31:0]      ttl_ff;

   logic             kind_ff;
   logic [31:0]      ip_ff;
   logic [47:0]      mac_ff;
   logic [31:0]      now_ff;
   logic [31:0]      exp_ff;
   logic [31:0]      exp_in;

   logic [31:0]      key_mem [ENTRIES];
   logic [47:0]      mac_mem [ENTRIES];
   logic [31:0]      exp_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   logic [31:0]      rd_key_ff;
   logic [47:0]      rd_mac_ff;
   logic [31:0]      rd_exp_ff;
   logic             rd_vld_ff;

   logic [IDXW-1:0]  victim_ff;
   logic [IDXW-1:0]  victim_in;
   logic [IDXW-1:0]  waddr;

   logic [31:0]      eff_key;
   logic [47:0]      eff_mac;
   logic [31:0]      eff_exp;

   logic             rsp_strobe_ff;
   logic             rsp_hit_ff;
   logic [47:0]      rsp_mac_ff;

   assign ttl    = ttl_ff;
   assign exp_in = req_now_ms + ttl_ff;

   assign victim_in = (victim_ff == LAST_IDX) ? '0 : victim_ff + 1'b1;
   assign waddr     = cmd.wr_victim ? victim_ff : wr_addr;

   // An entry never written since reset reads as all zeros.
   assign eff_key = rd_vld_ff ? rd_key_ff : '0;
   assign eff_mac = rd_vld_ff ? rd_mac_ff : '0;
   assign eff_exp = rd_vld_ff ? rd_exp_ff : '0;

   always_comb begin
      status.key_match = (eff_key == ip_ff);
      status.live      = (eff_exp > now_ff);
      status.is_lookup = (kind_ff == KIND_LOOKUP);
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_mac_out = rsp_mac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff        <= RESET_TTL_MS;
         valid_ff      <= '0;
         victim_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cfg_we) begin
            ttl_ff <= cfg_wdata;
         end
         if (cmd.wr_en) begin
            valid_ff[waddr] <= 1'b1;
            if (cmd.wr_victim) begin
               victim_ff <= victim_in;
            end
         end
         rsp_strobe_ff <= cmd.rsp_load;
      end
   end

   // Captured item and result payload.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         ip_ff   <= req_ip_addr;
         mac_ff  <= req_mac_in;
         now_ff  <= req_now_ms;
         exp_ff  <= exp_in;
      end
      if (cmd.rsp_load) begin
         rsp_hit_ff <= cmd.rsp_hit;
         rsp_mac_ff <= cmd.rsp_hit ? eff_mac : '0;
      end
   end

   // Entry store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         key_mem[waddr] <= ip_ff;
         mac_mem[waddr] <= mac_ff;
         exp_mem[waddr] <= exp_ff;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_mac_ff <= mac_mem[rd_addr];
      rd_exp_ff <= exp_mem[rd_addr];
      rd_vld_ff <= valid_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== src/arp_cache_ttl_round_robin_unit.sv =====
// IPv4-to-MAC cache with a time-to-live on every entry. Pulse start while busy
// is low to hand over an item: an insert (req_kind 0) refreshes the first entry
// holding req_ip_addr or fills the round-robin slot, with expiry
// req_now_ms + ttl_ms; a lookup (req_kind 1) reports the lowest-index entry
// whose key matches and whose expiry is still ahead of req_now_ms. The entries
// are read one a cycle through a single read port of the store, and busy stays
// high while the store is scanned and, for an insert, while the entry is
// written; a match ends the scan early. Each lookup gives one result, shown on
// rsp_hit and rsp_mac_out for exactly one cycle with rsp_strobe high, in the
// cycle in which busy falls. There is no way to hold a result off, so the
// receiver must take it in that cycle. Inserts give no result. The time-to-live
// register lies at byte address 0 of the APB port.
`default_nettype none

`include "assert_macros.svh"

module arp_cache_ttl_round_robin_unit #(
   parameter int ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_kind,
   input  wire logic [31:0] req_ip_addr,
   input  wire logic [47:0] req_mac_in,
   input  wire logic [31:0] req_now_ms,

   output logic             rsp_strobe,
   output logic             rsp_hit,
   output logic [47:0]      rsp_mac_out,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import arp_pkg::*;

   localparam int IDXW = $clog2(ENTRIES);

   cmd_type         cmd;
   stat_type        status;
   logic [IDXW-1:0] rd_addr;
   logic [IDXW-1:0] wr_addr;
   logic [31:0]     ttl;
   logic            cfg_we;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_TTL);
   assign prdata = (paddr[2] == REG_TTL) ? ttl : '0;

   arp_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .status  (status),
      .cmd     (cmd),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr)
   );

   arp_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr),
      .req_kind    (req_kind),
      .req_ip_addr (req_ip_addr),
      .req_mac_in  (req_mac_in),
      .req_now_ms  (req_now_ms),
      .cfg_we      (cfg_we),
      .cfg_wdata   (pwdata),
      .ttl         (ttl),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_hit     (rsp_hit),
      .rsp_mac_out (rsp_mac_out)
   );

   // An accepted item always makes the block busy in the following cycle.
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   // A result follows the end of a scan, never one in progress.
   `ASSERT_SAME(a_rsp_after_scan, clock, reset, rsp_strobe, !busy && $past(busy))
   // One item gives at most one result.
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe)
   // A miss carries a zero MAC.
   `ASSERT_SAME(a_miss_zero, clock, reset, rsp_strobe && !rsp_hit, rsp_mac_out == 48'd0)

endmodule

`default_nettype wire
